FILE: src/assert_macros.svh
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PHD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next clock edge outside reset
`define PHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/phd_pkg.sv
// types and constants of the packet header deframer
`default_nettype none

package phd_pkg;

  // configuration register indexes
  localparam logic [1:0] CfgSyncValue  = 2'd0;
  localparam logic [1:0] CfgCheckValue = 2'd1;
  localparam logic [1:0] CfgRxSizeCode = 2'd2;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // register reset values
  localparam logic [7:0]  SyncValueRst  = 8'd16;
  localparam logic [15:0] CheckValueRst = 16'd43690;
  localparam logic [3:0]  RxSizeCodeRst = 4'd2;

  // size codes
  localparam logic [7:0] CtrlSizeCode = 8'd9;
  localparam logic [3:0] MaxDataSize  = 4'd8;

  // header bytes held before the xor byte
  localparam int unsigned HeaderBody = 4;
  localparam logic [2:0]  LastBodyIdx = 3'd4;

  typedef enum logic [2:0] {
    StatusCtrlOk   = 3'd0,
    StatusDataOk   = 3'd1,
    StatusBadXor   = 3'd2,
    StatusBadCheck = 3'd3,
    StatusIgnored  = 3'd4
  } frame_status_e;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [15:0] check_value;
    logic [3:0]  rx_size_code;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  size_code;
    logic [15:0] check_word;
    logic [7:0]  control_byte;
    logic        xor_ok;
  } hdr_t;

endpackage

`default_nettype wire

FILE: src/phd_if.sv
// channel interfaces: received bytes in, frame results out
`default_nettype none

interface phd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface phd_frame_if;
  logic        valid;
  logic        ready;
  logic [2:0]  frame_status;
  logic [7:0]  control_byte;
  logic [15:0] check_word;
  logic [7:0]  size_code;

  modport source (output valid, output frame_status, output control_byte,
                  output check_word, output size_code, input ready);
  modport sink (input valid, input frame_status, input control_byte,
                input check_word, input size_code, output ready);
endinterface

`default_nettype wire

FILE: src/phd_collect.sv
// sync hunt and header byte collection, registers the finished header
`default_nettype none

module phd_collect (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          beat_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic [7:0]    sync_value_i,
  input  wire logic          hdr_take_i,
  output logic               hdr_valid_o,
  output phd_pkg::hdr_t      hdr_o
);

  logic       collecting_q, collecting_d;
  logic [2:0] idx_q, idx_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] store_q [phd_pkg::HeaderBody];
  logic       store_we;
  logic       hdr_load;
  logic       hdr_valid_q, hdr_valid_d;
  phd_pkg::hdr_t hdr_q, hdr_d;

  always_comb begin
    collecting_d = collecting_q;
    idx_d        = idx_q;
    xor_d        = xor_q;
    store_we     = 1'b0;
    hdr_load     = 1'b0;
    if (beat_i) begin
      if (!collecting_q) begin
        if (byte_i == sync_value_i) begin
          collecting_d = 1'b1;
          idx_d        = '0;
          xor_d        = '0;
        end
      end else if (idx_q != phd_pkg::LastBodyIdx) begin
        store_we = 1'b1;
        xor_d    = xor_q ^ byte_i;
        idx_d    = idx_q + 3'd1;
      end else begin
        // fifth byte is the header xor
        hdr_load     = 1'b1;
        collecting_d = 1'b0;
        idx_d        = '0;
        xor_d        = '0;
      end
    end
  end

  always_comb begin
    hdr_d.size_code    = store_q[0];
    hdr_d.check_word   = {store_q[2], store_q[1]};
    hdr_d.control_byte = store_q[3];
    hdr_d.xor_ok       = (xor_q == byte_i);
  end

  always_comb begin
    hdr_valid_d = hdr_valid_q;
    if (hdr_load) begin
      hdr_valid_d = 1'b1;
    end else if (hdr_take_i) begin
      hdr_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      idx_q        <= '0;
      xor_q        <= '0;
      hdr_valid_q  <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      idx_q        <= idx_d;
      xor_q        <= xor_d;
      hdr_valid_q  <= hdr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[idx_q[1:0]] <= byte_i;
    end
    if (hdr_load) begin
      hdr_q <= hdr_d;
    end
  end

  assign hdr_valid_o = hdr_valid_q;
  assign hdr_o       = hdr_q;

endmodule

`default_nettype wire

FILE: src/phd_classify.sv
// frame classification and the result register
`default_nettype none

module phd_classify (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          hdr_valid_i,
  input  wire phd_pkg::hdr_t hdr_i,
  input  wire phd_pkg::cfg_t cfg_i,
  input  wire logic          out_ready_i,
  output logic               hdr_take_o,
  output logic               out_valid_o,
  output phd_pkg::frame_status_e status_o,
  output phd_pkg::hdr_t      out_hdr_o
);

  logic                   out_valid_q, out_valid_d;
  logic                   take;
  logic [15:0]            total;
  logic                   data_ok;
  phd_pkg::frame_status_e status_d, status_q;
  phd_pkg::hdr_t          out_hdr_q;

  assign take  = hdr_valid_i && (!out_valid_q || out_ready_i);
  assign total = hdr_i.check_word + {8'd0, hdr_i.control_byte};

  // a data header needs a legal receive size code that matches
  assign data_ok = (cfg_i.rx_size_code != 4'd0)
                && (cfg_i.rx_size_code <= phd_pkg::MaxDataSize)
                && (hdr_i.size_code == {4'd0, cfg_i.rx_size_code});

  always_comb begin
    priority if (!hdr_i.xor_ok) begin
      status_d = phd_pkg::StatusBadXor;
    end else if (hdr_i.size_code == phd_pkg::CtrlSizeCode) begin
      status_d = (total == cfg_i.check_value) ? phd_pkg::StatusCtrlOk
                                              : phd_pkg::StatusBadCheck;
    end else if (data_ok) begin
      status_d = phd_pkg::StatusDataOk;
    end else begin
      status_d = phd_pkg::StatusIgnored;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q  <= status_d;
      out_hdr_q <= hdr_i;
    end
  end

  assign hdr_take_o  = take;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_hdr_o   = out_hdr_q;

endmodule

`default_nettype wire

FILE: src/packet_header_deframer_top.sv
// packet header deframer: sync hunt, header collection and frame classification
//
// rx_i carries one received line byte per beat; frame_o carries one result
// per complete header: status, control byte, check word and size code.
// the block hunts for the sync byte, takes the next four bytes as header body
// and the fifth as header xor, and on that fifth byte produces one result.
// all other bytes produce nothing.
// a result is valid once it has been loaded into the header register and
// then into the result register, after the beat of the xor byte.
// throughput: one byte per cycle while rx_i.ready is high; the header
// register and the result register form a two-deep pipe, so the byte
// stream keeps flowing while a result waits to be taken.
// when frame_o stalls and both registers hold a result, rx_i.ready drops
// until the result register empties.
// configuration: cfg_we_i writes register cfg_idx_i (0 sync value, 1 check
// value, 2 receive size code) with cfg_data_i; write only while idle.
// reset clears hunt state and pipe valids and loads register defaults;
// no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module packet_header_deframer_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [phd_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  wire logic [phd_pkg::CfgDataWidth-1:0]  cfg_data_i,
  phd_rx_if.sink                                 rx_i,
  phd_frame_if.source                            frame_o
);

  phd_pkg::cfg_t          cfg_q, cfg_d;
  phd_pkg::hdr_t          hdr;
  phd_pkg::hdr_t          out_hdr;
  phd_pkg::frame_status_e status;
  logic                   hdr_valid;
  logic                   hdr_take;
  logic                   out_valid;
  logic                   beat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        phd_pkg::CfgSyncValue:  cfg_d.sync_value   = cfg_data_i[7:0];
        phd_pkg::CfgCheckValue: cfg_d.check_value  = cfg_data_i;
        phd_pkg::CfgRxSizeCode: cfg_d.rx_size_code = cfg_data_i[3:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_value   <= phd_pkg::SyncValueRst;
      cfg_q.check_value  <= phd_pkg::CheckValueRst;
      cfg_q.rx_size_code <= phd_pkg::RxSizeCodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // header register may refill in the cycle it drains
  assign rx_i.ready = !hdr_valid || hdr_take;
  assign beat       = rx_i.valid && rx_i.ready;

  phd_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .byte_i       (rx_i.rx_byte),
    .sync_value_i (cfg_q.sync_value),
    .hdr_take_i   (hdr_take),
    .hdr_valid_o  (hdr_valid),
    .hdr_o        (hdr)
  );

  phd_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hdr_valid_i (hdr_valid),
    .hdr_i       (hdr),
    .cfg_i       (cfg_q),
    .out_ready_i (frame_o.ready),
    .hdr_take_o  (hdr_take),
    .out_valid_o (out_valid),
    .status_o    (status),
    .out_hdr_o   (out_hdr)
  );

  assign frame_o.valid        = out_valid;
  assign frame_o.frame_status = status;
  assign frame_o.control_byte = out_hdr.control_byte;
  assign frame_o.check_word   = out_hdr.check_word;
  assign frame_o.size_code    = out_hdr.size_code;

  `PHD_ASSERT(a_ready_low_needs_hdr, clk_i, rst_ni, !rx_i.ready |-> hdr_valid, "ready low with empty header register")
  `PHD_ASSERT(a_result_from_hdr, clk_i, rst_ni, $rose(frame_o.valid) |-> $past(hdr_valid), "result without header")
  `PHD_ASSERT_NEXT(a_hdr_holds, clk_i, rst_ni, hdr_valid && !hdr_take, hdr_valid, "header dropped while stalled")

endmodule

`default_nettype wire
